// File: rtl/core/mppr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppr_pkg: shared types and codes for the page replacement unit
// Policy codes, register indexes and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package mppr_pkg;

  localparam int unsigned PolicyW = 3;
  localparam int unsigned FramesW = 5;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned CountW  = 32;

  localparam logic [PolicyW-1:0] POL_FIFO  = 3'd0;
  localparam logic [PolicyW-1:0] POL_LRU   = 3'd1;
  localparam logic [PolicyW-1:0] POL_LFU   = 3'd2;
  localparam logic [PolicyW-1:0] POL_MFU   = 3'd3;
  localparam logic [PolicyW-1:0] POL_SCHN  = 3'd4;
  localparam logic [PolicyW-1:0] POL_CLOCK = 3'd5;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture input page, clear scan state
    logic look;      // compare one slot during lookup
    logic scan;      // one victim scan step
    logic commit;    // apply update and produce result
  } mppr_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic look_done;
    logic scan_done;
    logic need_scan;
  } mppr_sts_t;

endpackage

// File: rtl/core/multi_policy_page_replacement_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_policy_page_replacement_unit: page replacement with six policies
// Channel | direction | handshake
// ref     | in        | start / busy, page_i
// result  | out       | result_valid_o strobe, one cycle
// config  | in        | cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i
// One reference is looked up over the filled slots, one per cycle, until a hit
// or the last slot; an eviction under lfu, mfu, second chance or clock adds
// a victim scan through the single compare unit.
// Reset clears fill level, hand and fault count; no clearing pass.
// Config is taken only while idle. The receiver cannot stall: each result is
// shown for one cycle.
// ----------------------------------------------------------------------------
module multi_policy_page_replacement_unit
  import mppr_pkg::*;
#(
  parameter int unsigned FRAMES_MAX = 16,
  parameter int unsigned PAGE_BITS  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] page_i,
  output logic               result_valid_o,
  output logic               fault_o,
  output logic [SlotW-1:0]   slot_o,
  output logic               evicted_valid_o,
  output logic signed [31:0] evicted_page_o,
  output logic [CountW-1:0]  fault_total_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  mppr_cmd_t cmd;
  mppr_sts_t sts;
  logic [PolicyW-1:0] policy_q;
  logic [FramesW-1:0] frames_q;

  // configuration registers
  assign cfg_ready_o = !busy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIFO;
      frames_q <= FramesW'(16);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_POLICY) policy_q <= cfg_data_i[PolicyW-1:0];
      else                           frames_q <= cfg_data_i[FramesW-1:0];
    end
  end

  mppr_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  mppr_dp #(.FRAMES_MAX(FRAMES_MAX), .PAGE_BITS(PAGE_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .page_i,
    .policy_i(policy_q), .frames_i(frames_q), .valid_o(result_valid_o),
    .fault_o, .slot_o, .evicted_valid_o, .evicted_page_o, .fault_total_o
  );

endmodule

// File: rtl/core/mppr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppr_ctrl: sequencer for the page replacement unit
// Steps one reference through lookup, victim scan and commit.
// ----------------------------------------------------------------------------
module mppr_ctrl
  import mppr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  mppr_sts_t sts_i,
  output mppr_cmd_t cmd_o,
  output logic      busy_o
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SCAN, S_COMMIT} state_e;

  state_e state_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:   if (start_i) state_q <= S_LOOK;
        S_LOOK:   if (sts_i.look_done) state_q <= sts_i.need_scan ? S_SCAN : S_COMMIT;
        S_SCAN:   if (sts_i.scan_done) state_q <= S_COMMIT;
        S_COMMIT: state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && start_i;
    cmd_o.look   = (state_q == S_LOOK);
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.commit = (state_q == S_COMMIT);
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: rtl/core/mppr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppr_dp: datapath of the page replacement unit
// Slot store, load order queue, use counts, reference flags and clock hand.
// ----------------------------------------------------------------------------
module mppr_dp
  import mppr_pkg::*;
#(
  parameter int unsigned FRAMES_MAX = 16,
  parameter int unsigned PAGE_BITS  = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mppr_cmd_t               cmd_i,
  output mppr_sts_t               sts_o,
  input  logic signed [31:0]      page_i,
  input  logic [PolicyW-1:0]      policy_i,
  input  logic [FramesW-1:0]      frames_i,
  output logic                    valid_o,
  output logic                    fault_o,
  output logic [SlotW-1:0]        slot_o,
  output logic                    evicted_valid_o,
  output logic signed [31:0]      evicted_page_o,
  output logic [CountW-1:0]       fault_total_o
);

  localparam int unsigned IdxW  = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1;
  localparam int unsigned FillW = $clog2(FRAMES_MAX + 1);
  localparam int unsigned PgW   = (PAGE_BITS < 32) ? PAGE_BITS : 32;

  logic [PAGE_BITS-1:0] slot_page_q [FRAMES_MAX];
  logic [IdxW-1:0]      order_q     [FRAMES_MAX];
  logic [CountW-1:0]    use_q       [FRAMES_MAX];
  logic [FRAMES_MAX-1:0] ref_q;
  logic [FillW-1:0]     fill_q;
  logic [IdxW-1:0]      hand_q;
  logic [CountW-1:0]    faults_q;

  logic [PAGE_BITS-1:0] pg_q;
  logic [FillW-1:0]     k_q;        // lookup / scan position
  logic                 hit_q;
  logic [IdxW-1:0]      s_q;        // hit slot or victim slot
  logic [IdxW-1:0]      qpos_q;     // queue position to remove
  logic                 full_q;
  logic                 scan_end_q; // victim slot known, qpos search pending
  logic [IdxW-1:0]      best_q;

  // effective frame limit
  logic [FillW-1:0] limit;
  always_comb begin
    if (frames_i == '0) limit = FillW'(1);
    else if ({27'd0, frames_i} > FRAMES_MAX) limit = FillW'(FRAMES_MAX);
    else limit = FillW'(frames_i);
  end

  // input page widened to PAGE_BITS
  logic [PAGE_BITS-1:0] pg_in;
  always_comb begin
    pg_in = '0;
    pg_in[PgW-1:0] = page_i[PgW-1:0];
  end

  logic [IdxW-1:0] k_idx;
  assign k_idx = k_q[IdxW-1:0];
  logic k_last;
  assign k_last = (k_q + FillW'(1) >= fill_q);

  logic is_cnt, is_fifo;
  assign is_cnt  = (policy_i == POL_LFU) || (policy_i == POL_MFU);
  assign is_fifo = !is_cnt && (policy_i != POL_SCHN) && (policy_i != POL_CLOCK);

  logic look_end;
  assign look_end = (fill_q == '0) || (slot_page_q[k_idx] == pg_q) || k_last;

  assign sts_o.look_done = look_end;
  assign sts_o.need_scan = !((fill_q != '0) && (slot_page_q[k_idx] == pg_q))
                           && (fill_q >= limit) && !is_fifo;

  // scan step conditions
  logic [IdxW-1:0] sc_slot;
  assign sc_slot = order_q[k_idx];
  logic [FillW-1:0] fill_m1;
  assign fill_m1 = fill_q - FillW'(1);
  logic [IdxW-1:0] hand_nx;
  assign hand_nx = (FillW'(hand_q) + FillW'(1) >= fill_q) ? '0 : hand_q + IdxW'(1);

  assign sts_o.scan_done = scan_end_q && ((order_q[k_idx] == s_q) || k_last);

  // queue positions that hold slot s within the fill level
  logic [FRAMES_MAX-1:0] sel_pos;
  always_comb begin
    for (int i = 0; i < FRAMES_MAX; i++)
      sel_pos[i] = (order_q[i] == s_q) && (FillW'(i) < fill_q);
  end

  // first queue position holding the hit slot
  function automatic logic [FillW-1:0] k_pos(input logic [FRAMES_MAX-1:0] v);
    logic [FillW-1:0] r;
    r = '0;
    for (int i = FRAMES_MAX - 1; i >= 0; i--) if (v[i]) r = FillW'(i);
    return r;
  endfunction

  // main sequential datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      hand_q     <= '0;
      faults_q   <= '0;
      ref_q      <= '0;
      valid_o    <= 1'b0;
      k_q        <= '0;
      hit_q      <= 1'b0;
      scan_end_q <= 1'b0;
      full_q     <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      if (cmd_i.load) begin
        pg_q       <= pg_in;
        k_q        <= '0;
        hit_q      <= 1'b0;
        scan_end_q <= 1'b0;
        best_q     <= '0;
        qpos_q     <= '0;
        s_q        <= order_q[0];
        if (policy_i == POL_CLOCK && {1'b0, hand_q} >= fill_q) hand_q <= '0;
      end
      // lookup: one slot a cycle
      if (cmd_i.look) begin
        full_q <= (fill_q >= limit);
        if (fill_q != '0 && slot_page_q[k_idx] == pg_q) begin
          hit_q <= 1'b1;
          s_q   <= k_idx;
        end else if (!look_end) begin
          k_q <= k_q + FillW'(1);
        end else begin
          k_q <= is_cnt ? FillW'(1) : '0;
        end
      end
      // victim scan
      if (cmd_i.scan) begin
        if (scan_end_q) begin
          // search queue position of victim
          if (order_q[k_idx] == s_q) qpos_q <= k_idx;
          else k_q <= k_q + FillW'(1);
        end else begin
          priority case (1'b1)
            is_cnt: begin
              if (fill_q <= FillW'(1) || k_q >= fill_q) begin
                s_q <= best_q; k_q <= '0; scan_end_q <= 1'b1;
              end else begin
                if ((policy_i == POL_LFU) ? (use_q[k_idx] < use_q[best_q])
                                          : (use_q[k_idx] > use_q[best_q]))
                  best_q <= k_idx;
                k_q <= k_q + FillW'(1);
              end
            end
            (policy_i == POL_SCHN): begin
              if (k_q >= fill_q) begin
                s_q <= order_q[0]; k_q <= '0; scan_end_q <= 1'b1;
              end else if (ref_q[sc_slot]) begin
                ref_q[sc_slot] <= 1'b0;
                k_q <= k_q + FillW'(1);
              end else begin
                s_q <= sc_slot; scan_end_q <= 1'b1;
              end
            end
            default: begin // clock
              if (ref_q[hand_q]) begin
                ref_q[hand_q] <= 1'b0;
                hand_q <= hand_nx;
              end else begin
                s_q <= hand_q; k_q <= '0; scan_end_q <= 1'b1;
              end
            end
          endcase
        end
      end
      // commit
      if (cmd_i.commit) begin
        valid_o <= 1'b1;
        evicted_valid_o <= 1'b0;
        evicted_page_o  <= '0;
        if (hit_q) begin
          fault_o <= 1'b0;
          slot_o  <= SlotW'(s_q);
          if (use_q[s_q] != '1) use_q[s_q] <= use_q[s_q] + CountW'(1);
          ref_q[s_q] <= 1'b1;
          hand_q <= s_q;
          if (policy_i == POL_LRU) begin
            for (int i = 0; i < FRAMES_MAX; i++) begin
              if (FillW'(i) >= k_pos(sel_pos) && FillW'(i) + FillW'(1) < fill_q)
                order_q[i] <= order_q[(i + 1) % FRAMES_MAX];
            end
            order_q[fill_m1[IdxW-1:0]] <= s_q;
          end
        end else begin
          fault_o <= 1'b1;
          if (faults_q != '1) faults_q <= faults_q + CountW'(1);
          if (!full_q) begin
            slot_o <= SlotW'(fill_q);
            slot_page_q[fill_q[IdxW-1:0]] <= pg_q;
            use_q[fill_q[IdxW-1:0]] <= CountW'(1);
            ref_q[fill_q[IdxW-1:0]] <= 1'b0;
            order_q[fill_q[IdxW-1:0]] <= fill_q[IdxW-1:0];
            hand_q <= fill_q[IdxW-1:0];
            fill_q <= fill_q + FillW'(1);
          end else begin
            slot_o <= SlotW'(s_q);
            evicted_valid_o <= 1'b1;
            evicted_page_o  <= 32'(slot_page_q[s_q]);
            slot_page_q[s_q] <= pg_q;
            use_q[s_q] <= CountW'(1);
            ref_q[s_q] <= 1'b0;
            if (policy_i == POL_CLOCK) hand_q <= s_q;
            for (int i = 0; i < FRAMES_MAX; i++) begin
              if (FillW'(i) >= FillW'(qpos_q) && FillW'(i) + FillW'(1) < fill_q)
                order_q[i] <= order_q[(i + 1) % FRAMES_MAX];
            end
            order_q[fill_m1[IdxW-1:0]] <= s_q;
          end
        end
      end
    end
  end

  // count already includes the fault of the beat on show
  assign fault_total_o = faults_q;

endmodule

// File: rtl/core/mppr_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppr_chk: port-level checks for the page replacement unit
// Watches start, busy and the result strobe.
// ----------------------------------------------------------------------------
module mppr_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic fault_o,
  input logic evicted_valid_o
);
  // accepted beat makes the unit busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised");
  // result only ends a busy period
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("stray result");
  // eviction is always a fault
  a_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && evicted_valid_o |-> fault_o) else $error("eviction on hit");
endmodule

bind multi_policy_page_replacement_unit mppr_chk u_chk (
  .clk_i, .rst_ni, .start, .busy, .result_valid_o, .fault_o, .evicted_valid_o
);

// File: tb/multi_policy_page_replacement_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_policy_page_replacement_unit_tb: self-checking bench for the pager
// Directed references followed by random traffic under every policy and a
// range of frame counts; each result beat is checked against a local model or a typed-in result.
// ----------------------------------------------------------------------------
module multi_policy_page_replacement_unit_tb;
  import mppr_pkg::*;

  localparam int unsigned NF       = 16;
  localparam int unsigned WDOG_MAX = 4000;
  localparam int unsigned DRAIN    = 80;
  localparam int unsigned NDIR     = 8;

  // result beat
  typedef struct packed {
    logic        fault;
    logic [3:0]  slot;
    logic        ev_valid;
    logic [31:0] ev_page;
    logic [31:0] total;
  } pres_t;

  // directed row: page, whether the result is typed in, and that result
  typedef struct {
    logic [31:0] page;
    bit          typed;
    pres_t       res;
  } drow_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] page_i = '0;
  logic result_valid_o, fault_o, evicted_valid_o, cfg_ready_o;
  logic [SlotW-1:0] slot_o;
  logic signed [31:0] evicted_page_o;
  logic [CountW-1:0] fault_total_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  multi_policy_page_replacement_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [2:0]  m_pol;
  logic [4:0]  m_frames;
  logic [31:0] m_page [NF];
  logic [4:0]  m_fill;
  logic [3:0]  m_order [NF];
  logic [31:0] m_use [NF];
  bit          m_ref [NF];
  logic [3:0]  m_hand;
  logic [31:0] m_faults;

  pres_t pending_q[$];
  int    errors = 0;
  int    refs_sent = 0;
  int    beats_seen = 0;
  int    idle_pct = 0;
  int    wdog = 0;

  function automatic int order_pos(input int s);
    for (int k = 0; k < m_fill; k++) if (m_order[k] == s) return k;
    return 0;
  endfunction

  function automatic void order_to_back(input int pos, input int s);
    for (int k = pos; k + 1 < m_fill; k++) m_order[k] = m_order[k+1];
    if (m_fill > 0) m_order[m_fill-1] = s[3:0];
  endfunction

  // pick replacement slot; pos returns its place in the load order
  function automatic int choose_victim(output int pos);
    int best, k;
    pos = 0;
    case (m_pol)
      POL_LFU, POL_MFU: begin
        best = 0;
        for (k = 1; k < m_fill; k++)
          if (m_pol == POL_LFU ? (m_use[k] < m_use[best]) : (m_use[k] > m_use[best]))
            best = k;
        pos = order_pos(best);
        return best;
      end
      POL_SCHN: begin
        for (k = 0; k < m_fill && m_ref[m_order[k]]; k++) m_ref[m_order[k]] = 0;
        if (k >= m_fill) k = 0;
        pos = k;
        return m_order[k];
      end
      POL_CLOCK: begin
        if (m_hand >= m_fill) m_hand = 0;
        while (m_ref[m_hand]) begin
          m_ref[m_hand] = 0;
          m_hand = (m_hand + 1 >= m_fill) ? 4'd0 : m_hand + 4'd1;
        end
        pos = order_pos(m_hand);
        return m_hand;
      end
      default: return m_order[0];
    endcase
  endfunction

  function automatic pres_t predict_ref(input logic [31:0] pg);
    pres_t r;
    int lim, s, pos;
    bit hit;
    lim = (m_frames < 1) ? 1 : (m_frames > NF) ? NF : m_frames;
    hit = 0; s = 0;
    for (int k = 0; k < m_fill; k++)
      if (!hit && m_page[k] == pg) begin
        hit = 1; s = k;
      end
    r = '0;
    if (hit) begin
      if (m_use[s] != 32'hFFFF_FFFF) m_use[s]++;
      m_ref[s] = 1;
      m_hand = s[3:0];
      if (m_pol == POL_LRU) order_to_back(order_pos(s), s);
    end else begin
      if (m_faults != 32'hFFFF_FFFF) m_faults++;
      if (m_fill < lim) begin
        s = m_fill;
        m_fill++;
        m_order[s] = s[3:0];
        m_hand = s[3:0];
      end else begin
        s = choose_victim(pos);
        r.ev_valid = 1'b1;
        r.ev_page = m_page[s];
        order_to_back(pos, s);
      end
      m_page[s] = pg;
      m_use[s] = 1;
      m_ref[s] = 0;
      r.fault = 1'b1;
    end
    r.slot = s[3:0];
    r.total = m_faults;
    return r;
  endfunction

  // result checker and idle watchdog
  always @(posedge clk_i) begin
    pres_t got, want;
    if (result_valid_o) begin
      got = '{fault_o, slot_o, evicted_valid_o, evicted_page_o, fault_total_o};
      beats_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.fault !== want.fault)
          $display("%0t: fault exp %0b got %0b", $time, want.fault, got.fault);
        if (got.slot !== want.slot)
          $display("%0t: slot exp %0d got %0d", $time, want.slot, got.slot);
        if (got.ev_valid !== want.ev_valid)
          $display("%0t: evicted_valid exp %0b got %0b", $time, want.ev_valid, got.ev_valid);
        if (got.ev_page !== want.ev_page)
          $display("%0t: evicted_page exp %h got %h", $time, want.ev_page, got.ev_page);
        if (got.total !== want.total)
          $display("%0t: fault_total exp %0d got %0d", $time, want.total, got.total);
        if (got !== want) errors++;
      end
    end
    if (result_valid_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) wdog = 0;
    else wdog++;
    if (wdog >= WDOG_MAX) begin
      $display("%0t: watchdog expired", $time);
      $display("FAILURE");
      $finish;
    end
  end

  // one register write; cfg_valid_i is dropped before returning, keeping back-to-back writes apart
  task automatic write_reg(input logic idx, input logic [31:0] val);
    start <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_POLICY) m_pol = val[2:0];
    else m_frames = val[4:0];
    @(posedge clk_i);
  endtask

  // wait for all results plus settle time before touching registers
  task automatic drain_all();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // one reference beat; predicted result queued unless directed value given
  task automatic send_ref(input logic [31:0] pg, input bit typed, input pres_t res);
    pres_t p;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    page_i <= pg;
    do @(posedge clk_i); while (busy);
    p = predict_ref(pg);
    pending_q.insert(pending_q.size(), typed ? res : p);
    refs_sent++;
  endtask

  function automatic logic [31:0] rand_page(input int span);
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'h8000_0000 ^ $urandom_range(span);
      default: return $urandom_range(span);
    endcase
  endfunction

  drow_t dtab [NDIR];

  initial begin
    logic [31:0] ext [4];
    int lim;
    ext = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    m_pol = POL_FIFO; m_frames = 5'd16; m_fill = 0; m_hand = 0; m_faults = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: four extremes into empty frames, then hits on them
    for (int i = 0; i < 4; i++)
      dtab[i] = '{ext[i], 1'b1, '{1'b1, i[3:0], 1'b0, 32'h0, i + 1}};
    for (int i = 0; i < 4; i++)
      dtab[i + 4] = '{ext[i], 1'b1, '{1'b0, i[3:0], 1'b0, 32'h0, 32'd4}};
    foreach (dtab[i]) send_ref(dtab[i].page, dtab[i].typed, dtab[i].res);
    drain_all();

    // directed: each policy with two frames, including out-of-range codes
    write_reg(REG_FRAMES, 32'd2);
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_POLICY, p);
      send_ref(32'd10 + p, 0, '0);
      send_ref(32'h8000_0000, 0, '0);
      send_ref(32'd10 + p, 0, '0);
      send_ref(32'd77, 0, '0);
      drain_all();
    end
    // frame count zero and above the maximum
    write_reg(REG_FRAMES, 32'd0);
    send_ref(32'd3, 0, '0);
    drain_all();
    write_reg(REG_FRAMES, 32'd31);
    send_ref(32'd4, 0, '0);
    drain_all();

    // random phases, sweeping policy and frame count with three idle modes
    for (int ph = 0; ph < 27; ph++) begin
      idle_pct = (ph < 9) ? 19 : (ph < 18) ? 69 : 0;
      write_reg(REG_POLICY, ph % 6);
      case (ph % 4)
        0: lim = 1;
        1: lim = 16;
        default: lim = $urandom_range(2, 16);
      endcase
      write_reg(REG_FRAMES, lim);
      for (int i = 0; i < 16; i++) send_ref(rand_page(lim + 3), 0, '0);
      drain_all();
    end

    drain_all();
    $display("Covered %0d references, %0d result beats, all six policies and codes 6/7,",
             refs_sent, beats_seen);
    $display("frame counts from zero to above the maximum, with and without sender idling.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: multi_policy_page_replacement_unit.f
rtl/core/mppr_pkg.sv
rtl/core/mppr_ctrl.sv
rtl/core/mppr_dp.sv
rtl/core/multi_policy_page_replacement_unit.sv
rtl/core/mppr_chk.sv
tb/multi_policy_page_replacement_unit_tb.sv
